@@ rtl/core/stok_pkg.sv @@
package stok_pkg;

  localparam int unsigned PosBitsDefault   = 16;
  localparam int unsigned FifoDepthDefault = 4;
  localparam int unsigned OutPosBits       = 16;

  localparam logic [4:0] TAG_INTEGER = 5'd6;
  localparam logic [4:0] TAG_IDENT   = 5'd7;
  localparam logic [4:0] TAG_LPAREN  = 5'd8;
  localparam logic [4:0] TAG_RPAREN  = 5'd9;
  localparam logic [4:0] TAG_LBRACE  = 5'd10;
  localparam logic [4:0] TAG_RBRACE  = 5'd11;
  localparam logic [4:0] TAG_COMMA   = 5'd12;
  localparam logic [4:0] TAG_COLON   = 5'd13;
  localparam logic [4:0] TAG_SEMI    = 5'd14;
  localparam logic [4:0] TAG_EQUALS  = 5'd15;
  localparam logic [4:0] TAG_PLUS    = 5'd16;
  localparam logic [4:0] TAG_EOF     = 5'd17;
  localparam logic [4:0] TAG_INVALID = 5'd18;

  localparam logic [5:0] KW_ALL = 6'h3F;

  // Keyword text, first character in the low byte.
  localparam logic [5:0][3:0][7:0] KW_TEXT = {
    {8'h00, "rav"}, {8'h00, "lav"}, "tinu", "tinU", {8'h00, "tnI"}, {8'h00, "nuf"}
  };
  localparam logic [5:0][2:0] KW_LEN = {3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3};

  typedef enum logic [5:0] {
    MODE_START   = 6'b000001,
    MODE_IDENT   = 6'b000010,
    MODE_INT     = 6'b000100,
    MODE_SLASH   = 6'b001000,
    MODE_COMMENT = 6'b010000,
    MODE_INVALID = 6'b100000
  } stok_mode_e;

  typedef struct packed {
    logic [4:0]            tag;
    logic [OutPosBits-1:0] start;
    logic [OutPosBits-1:0] stop;
  } stok_token_t;

  typedef struct packed {
    stok_token_t tok0;
    stok_token_t tok1;
    logic        two;
  } stok_entry_t;

  function automatic logic [5:0] kw_track(logic [5:0] cands, logic [2:0] len, logic [7:0] c);
    logic [5:0] res;
    res = cands;
    for (int i = 0; i < 6; i++) begin
      if (!((len < KW_LEN[i]) && (KW_TEXT[i][len[1:0]] == c))) begin
        res[i] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic [4:0] kw_tag(logic [5:0] cands, logic [2:0] len);
    logic [4:0] res;
    res = TAG_IDENT;
    for (int i = 5; i >= 0; i--) begin
      if (cands[i] && (KW_LEN[i] == len)) begin
        res = 5'(i);
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/stok_front.sv @@
module stok_front
  import stok_pkg::*;
#(
  parameter int unsigned POS_BITS = PosBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  ch_i,
  input  logic        end_of_input_i,
  output logic        entry_valid_o,
  output stok_entry_t entry_o
);

  stok_mode_e          mode_q, mode_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] pstart_q, pstart_d;
  logic [5:0]          cand_q, cand_d;
  logic [2:0]          ilen_q, ilen_d;

  logic                close;
  logic [4:0]          close_tag;
  logic                do_start;
  logic                st_emit;
  logic [4:0]          st_tag;
  logic [POS_BITS-1:0] st_end;
  logic                is_punct;
  logic [4:0]          punct_tag;
  logic                is_letter, is_numeral, is_word, is_space;
  logic [POS_BITS-1:0] pos_inc;
  stok_token_t         close_tok, start_tok;

  assign is_letter  = ((ch_i >= "a") && (ch_i <= "z")) || ((ch_i >= "A") && (ch_i <= "Z"));
  assign is_numeral = (ch_i >= "0") && (ch_i <= "9");
  assign is_word    = is_letter || is_numeral || (ch_i == "_");
  assign is_space   = (ch_i == " ") || (ch_i == 8'h0A) || (ch_i == 8'h09) || (ch_i == 8'h0D);
  assign pos_inc    = (pos_q == '1) ? pos_q : pos_q + POS_BITS'(1);

  always_comb begin
    is_punct  = 1'b1;
    punct_tag = TAG_INVALID;
    unique case (ch_i)
      "(":     punct_tag = TAG_LPAREN;
      ")":     punct_tag = TAG_RPAREN;
      "{":     punct_tag = TAG_LBRACE;
      "}":     punct_tag = TAG_RBRACE;
      ",":     punct_tag = TAG_COMMA;
      ":":     punct_tag = TAG_COLON;
      ";":     punct_tag = TAG_SEMI;
      "=":     punct_tag = TAG_EQUALS;
      "+":     punct_tag = TAG_PLUS;
      default: is_punct = 1'b0;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    pstart_d  = pstart_q;
    cand_d    = cand_q;
    ilen_d    = ilen_q;
    close     = 1'b0;
    close_tag = TAG_INVALID;
    do_start  = 1'b0;
    st_emit   = 1'b0;
    st_tag    = TAG_EOF;
    st_end    = pos_q;

    unique case (mode_q)
      MODE_IDENT: begin
        if (!end_of_input_i && is_word) begin
          cand_d = kw_track(cand_q, ilen_q, ch_i);
          ilen_d = (ilen_q == 3'd7) ? ilen_q : ilen_q + 3'd1;
          pos_d  = pos_inc;
        end else begin
          close     = 1'b1;
          close_tag = kw_tag(cand_q, ilen_q);
          do_start  = 1'b1;
        end
      end
      MODE_INT: begin
        if (!end_of_input_i && (is_numeral || (ch_i == "_"))) begin
          pos_d = pos_inc;
        end else begin
          close     = 1'b1;
          close_tag = TAG_INTEGER;
          do_start  = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (!end_of_input_i && (ch_i == "/")) begin
          mode_d = MODE_COMMENT;
          pos_d  = pos_inc;
        end else begin
          close    = 1'b1;
          do_start = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (end_of_input_i) begin
          do_start = 1'b1;
        end else begin
          if (ch_i == 8'h0A) begin
            mode_d = MODE_START;
          end
          pos_d = pos_inc;
        end
      end
      MODE_INVALID: begin
        if (end_of_input_i || (ch_i == 8'h0A)) begin
          close    = 1'b1;
          do_start = 1'b1;
        end else begin
          pos_d = pos_inc;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    if (do_start) begin
      mode_d = MODE_START;
      priority if (end_of_input_i) begin
        st_emit  = 1'b1;
        st_tag   = TAG_EOF;
        st_end   = pos_q;
        pos_d    = '0;
        pstart_d = '0;
        cand_d   = KW_ALL;
        ilen_d   = 3'd0;
      end else if (is_space) begin
        pos_d = pos_inc;
      end else if (ch_i == "/") begin
        pstart_d = pos_q;
        mode_d   = MODE_SLASH;
        pos_d    = pos_inc;
      end else if (is_punct) begin
        st_emit = 1'b1;
        st_tag  = punct_tag;
        st_end  = pos_inc;
        pos_d   = pos_inc;
      end else if (is_letter || (ch_i == "_")) begin
        cand_d   = kw_track(KW_ALL, 3'd0, ch_i);
        ilen_d   = 3'd1;
        pstart_d = pos_q;
        mode_d   = MODE_IDENT;
        pos_d    = pos_inc;
      end else if (is_numeral) begin
        pstart_d = pos_q;
        mode_d   = MODE_INT;
        pos_d    = pos_inc;
      end else begin
        pstart_d = pos_q;
        mode_d   = MODE_INVALID;
        pos_d    = pos_inc;
      end
    end
  end

  assign close_tok.tag   = close_tag;
  assign close_tok.start = OutPosBits'(pstart_q);
  assign close_tok.stop  = OutPosBits'(pos_q);
  assign start_tok.tag   = st_tag;
  assign start_tok.start = OutPosBits'(pos_q);
  assign start_tok.stop  = OutPosBits'(st_end);

  assign entry_valid_o = accept_i && (close || st_emit);
  assign entry_o.tok0  = close ? close_tok : start_tok;
  assign entry_o.tok1  = start_tok;
  assign entry_o.two   = close && st_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_START;
      pos_q    <= '0;
      pstart_q <= '0;
      cand_q   <= KW_ALL;
      ilen_q   <= 3'd0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      cand_q   <= cand_d;
      ilen_q   <= ilen_d;
    end
  end

endmodule

@@ rtl/core/stok_fifo.sv @@
module stok_fifo
  import stok_pkg::*;
#(
  parameter int unsigned DEPTH = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  stok_entry_t wr_data_i,
  output logic        full_o,
  input  logic        rd_i,
  output logic        valid_o,
  output stok_entry_t rd_data_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(DEPTH);

  stok_entry_t        mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_wr, do_rd;

  assign full_o    = (cnt_q == CntFull);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/core/stok_back.sv @@
module stok_back
  import stok_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        entry_valid_i,
  input  stok_entry_t entry_i,
  output logic        entry_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output stok_token_t tok_o,
  output logic        last_o
);

  logic        out_valid_q, out_valid_d;
  logic        sub_q, sub_d;
  stok_token_t tok_q, tok_d;
  logic        last_q, last_d;
  logic        load;

  assign load = !out_valid_q || pop_i;

  always_comb begin
    out_valid_d = out_valid_q;
    sub_d       = sub_q;
    tok_d       = tok_q;
    last_d      = last_q;
    entry_pop_o = 1'b0;
    if (load) begin
      out_valid_d = entry_valid_i;
      if (entry_valid_i) begin
        if (entry_i.two && !sub_q) begin
          tok_d  = entry_i.tok0;
          last_d = 1'b0;
          sub_d  = 1'b1;
        end else begin
          tok_d       = entry_i.two ? entry_i.tok1 : entry_i.tok0;
          last_d      = 1'b1;
          sub_d       = 1'b0;
          entry_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    last_q <= last_d;
  end

  assign empty_o = !out_valid_q;
  assign tok_o   = tok_q;
  assign last_o  = last_q;

endmodule

@@ rtl/core/source_tokenizer_top.sv @@
// Channel  | Direction | Handshake    | Beat contents
// source   | in        | push / full  | ch_i, end_of_input_i
// tokens   | out       | pop / empty  | token_tag_o, token_start_o, token_end_o, last_o
//
// The scanner takes one source beat per cycle while its token queue has room.
// A beat that yields two tokens occupies the output register once for each token, the first with last_o low.
// Tokens pass from their source beat through the queue memory and then the output register.
// Reset returns the scanner to the start state at position zero and empties the queue.
// A stalled output fills the queue, after which full_o holds off further source beats.
module source_tokenizer_top
  import stok_pkg::*;
#(
  parameter int unsigned POS_BITS   = PosBitsDefault,
  parameter int unsigned FIFO_DEPTH = FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  ch_i,
  input  logic        end_of_input_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [4:0]  token_tag_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_end_o,
  output logic        last_o
);

  logic        accept;
  logic        wr_valid;
  stok_entry_t wr_entry;
  logic        rd_valid;
  logic        rd_pop;
  stok_entry_t rd_entry;
  stok_token_t tok;

  assign accept = push_i && !full_o;

  stok_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .ch_i          (ch_i),
    .end_of_input_i(end_of_input_i),
    .entry_valid_o (wr_valid),
    .entry_o       (wr_entry)
  );

  stok_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr_valid),
    .wr_data_i(wr_entry),
    .full_o   (full_o),
    .rd_i     (rd_pop),
    .valid_o  (rd_valid),
    .rd_data_o(rd_entry)
  );

  stok_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_valid_i(rd_valid),
    .entry_i      (rd_entry),
    .entry_pop_o  (rd_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .tok_o        (tok),
    .last_o       (last_o)
  );

  assign token_tag_o   = tok.tag;
  assign token_start_o = tok.start;
  assign token_end_o   = tok.stop;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import stok_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;

  localparam logic [4:0] TAG_FUN     = 5'd0;
  localparam logic [4:0] TAG_INT_KW  = 5'd1;
  localparam logic [4:0] TAG_UNIT_UC = 5'd2;
  localparam logic [4:0] TAG_UNIT_LC = 5'd3;
  localparam logic [4:0] TAG_VAL     = 5'd4;
  localparam logic [4:0] TAG_VAR     = 5'd5;
  localparam logic [5:0][4:0] KW_TAG = {
    TAG_VAR, TAG_VAL, TAG_UNIT_LC, TAG_UNIT_UC, TAG_INT_KW, TAG_FUN
  };

  typedef enum int {
    LX_KEYWORD, LX_IDENT, LX_NUMBER, LX_PUNCT, LX_SPACE, LX_COMMENT, LX_SLASH, LX_JUNK
  } lex_kind_e;

  typedef struct packed {
    logic [4:0]  tag;
    logic [15:0] first;
    logic [15:0] after;
    logic        last;
  } lexeme_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       typed;
    lexeme_t    want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic        full_o;
  logic [7:0]  ch_i = 8'h00;
  logic        end_of_input_i = 1'b0;
  logic        pop_i = 1'b0;
  logic        empty_o;
  logic [4:0]  token_tag_o;
  logic [15:0] token_start_o;
  logic [15:0] token_end_o;
  logic        last_o;

  source_tokenizer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .ch_i          (ch_i),
    .end_of_input_i(end_of_input_i),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .token_tag_o   (token_tag_o),
    .token_start_o (token_start_o),
    .token_end_o   (token_end_o),
    .last_o        (last_o)
  );

  string kw_word [6] = '{"fun", "Int", "Unit", "unit", "val", "var"};
  string IDENT_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  string PUNCT_CHARS = "(){},:;=+";
  string BLANK_CHARS = " \t\r\n";

  stok_mode_e       lex_mode;
  logic [15:0]      cur_pos;
  logic [15:0]      tok_begin;
  logic [3:0][7:0]  word_buf;
  int               word_len;

  lexeme_t     lexed[$];
  lexeme_t     expected_tokens[$];
  stim_row_t   stim_rows[$];
  logic [8:0]  src_beats[$];

  bit          steady_send = 1'b0;
  int unsigned err_count = 0;
  int unsigned beats_sent = 0;
  int unsigned tokens_checked = 0;
  int unsigned keyword_tokens = 0;
  int unsigned double_beats = 0;
  int unsigned sources = 0;
  int unsigned cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d tokens outstanding.", cycles,
               expected_tokens.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 30) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic bit alpha_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit numeral_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || c == "\t" || c == "\r" || c == "\n";
  endfunction

  function automatic logic [4:0] punct_tag(logic [7:0] c);
    case (c)
      "(": return TAG_LPAREN;
      ")": return TAG_RPAREN;
      "{": return TAG_LBRACE;
      "}": return TAG_RBRACE;
      ",": return TAG_COMMA;
      ":": return TAG_COLON;
      ";": return TAG_SEMI;
      "=": return TAG_EQUALS;
      "+": return TAG_PLUS;
      default: return TAG_INVALID;
    endcase
  endfunction

  function automatic bit starts_token(logic [7:0] c);
    return alpha_char(c) || numeral_char(c) || is_blank(c) || c == "_" || c == "/" ||
           punct_tag(c) != TAG_INVALID;
  endfunction

  function automatic logic [15:0] bump(logic [15:0] p);
    return (p == 16'hFFFF) ? p : p + 16'd1;
  endfunction

  task automatic clear_lexer();
    lex_mode  = MODE_START;
    cur_pos   = '0;
    tok_begin = '0;
    word_buf  = '0;
    word_len  = 0;
  endtask

  task automatic add_token(input logic [4:0] tag, input logic [15:0] s, input logic [15:0] f);
    lexeme_t t;
    t.tag   = tag;
    t.first = s;
    t.after = f;
    t.last  = 1'b0;
    lexed.push_back(t);
  endtask

  task automatic take_word_char(input logic [7:0] c);
    if (word_len < 4) word_buf[word_len] = c;
    if (word_len < 7) word_len++;
  endtask

  function automatic logic [4:0] word_tag();
    bit hit;
    for (int i = 0; i < 6; i++) begin
      if (word_len == kw_word[i].len()) begin
        hit = 1'b1;
        for (int k = 0; k < word_len; k++) begin
          if (word_buf[k] != kw_word[i][k]) hit = 1'b0;
        end
        if (hit) return KW_TAG[i];
      end
    end
    return TAG_IDENT;
  endfunction

  task automatic open_token(input stok_mode_e mode);
    tok_begin = cur_pos;
    lex_mode  = mode;
    cur_pos   = bump(cur_pos);
  endtask

  task automatic restart(input logic [7:0] c, input logic e);
    logic [15:0] nxt;
    lex_mode = MODE_START;
    if (e) begin
      add_token(TAG_EOF, cur_pos, cur_pos);
      clear_lexer();
    end else if (is_blank(c)) begin
      cur_pos = bump(cur_pos);
    end else if (c == "/") begin
      open_token(MODE_SLASH);
    end else if (punct_tag(c) != TAG_INVALID) begin
      nxt = bump(cur_pos);
      add_token(punct_tag(c), cur_pos, nxt);
      cur_pos = nxt;
    end else if (alpha_char(c) || c == "_") begin
      word_len = 0;
      take_word_char(c);
      open_token(MODE_IDENT);
    end else if (numeral_char(c)) begin
      open_token(MODE_INT);
    end else begin
      open_token(MODE_INVALID);
    end
  endtask

  task automatic lex_beat(input logic [7:0] c, input logic e);
    lexeme_t tail_tok;
    lexed.delete();
    case (lex_mode)
      MODE_IDENT: begin
        if (!e && (alpha_char(c) || numeral_char(c) || c == "_")) begin
          take_word_char(c);
          cur_pos = bump(cur_pos);
        end else begin
          add_token(word_tag(), tok_begin, cur_pos);
          restart(c, e);
        end
      end
      MODE_INT: begin
        if (!e && (numeral_char(c) || c == "_")) begin
          cur_pos = bump(cur_pos);
        end else begin
          add_token(TAG_INTEGER, tok_begin, cur_pos);
          restart(c, e);
        end
      end
      MODE_SLASH: begin
        if (!e && c == "/") begin
          lex_mode = MODE_COMMENT;
          cur_pos  = bump(cur_pos);
        end else begin
          add_token(TAG_INVALID, tok_begin, cur_pos);
          restart(c, e);
        end
      end
      MODE_COMMENT: begin
        if (e) begin
          restart(c, 1'b1);
        end else begin
          if (c == "\n") lex_mode = MODE_START;
          cur_pos = bump(cur_pos);
        end
      end
      MODE_INVALID: begin
        if (e || c == "\n") begin
          add_token(TAG_INVALID, tok_begin, cur_pos);
          restart(c, e);
        end else begin
          cur_pos = bump(cur_pos);
        end
      end
      default: restart(c, e);
    endcase
    if (lexed.size() > 0) begin
      tail_tok = lexed.pop_back();
      tail_tok.last = 1'b1;
      lexed.push_back(tail_tok);
    end
  endtask

  function automatic int idle_gap();
    int r;
    if (steady_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic e, input logic typed,
                           input lexeme_t want);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i         <= 1'b1;
    ch_i           <= c;
    end_of_input_i <= e;
    do @(posedge clk_i); while (full_o);
    lex_beat(c, e);
    beats_sent++;
    if (lexed.size() == 2) double_beats++;
    foreach (lexed[i]) begin
      if (lexed[i].tag <= TAG_VAR) keyword_tokens++;
    end
    if (typed) begin
      expected_tokens.push_back(want);
    end else begin
      foreach (lexed[i]) expected_tokens.push_back(lexed[i]);
    end
  endtask

  task automatic check_token();
    lexeme_t want;
    if (expected_tokens.size() == 0) begin
      flag_error($sformatf("token tag %0d [%0d,%0d) last %0b arrived with nothing expected",
                           token_tag_o, token_start_o, token_end_o, last_o));
    end else begin
      want = expected_tokens.pop_front();
      tokens_checked++;
      if (token_tag_o !== want.tag || token_start_o !== want.first ||
          token_end_o !== want.after || last_o !== want.last) begin
        flag_error($sformatf(
          "token %0d: got tag %0d [%0d,%0d) last %0b, want tag %0d [%0d,%0d) last %0b",
          tokens_checked, token_tag_o, token_start_o, token_end_o, last_o,
          want.tag, want.first, want.after, want.last));
      end
    end
  endtask

  initial begin
    int hold_left;
    int calm_left;
    int r;
    bit long_hold_done;
    hold_left = 0;
    calm_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop_i && !empty_o) check_token();
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else if (!long_hold_done && tokens_checked >= 60) begin
        // Stop draining long enough for the token queue to fill and push back.
        long_hold_done = 1'b1;
        hold_left = 400;
        pop_i <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        pop_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) calm_left = 40;
        if (r < 65) begin
          pop_i <= 1'b1;
        end else begin
          pop_i <= 1'b0;
          hold_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 25);
        end
      end
    end
  end

  task automatic row(input logic [7:0] c, input logic e);
    stim_row_t r;
    r       = '0;
    r.ch    = c;
    r.eoi   = e;
    stim_rows.push_back(r);
  endtask

  task automatic row_typed(input logic [7:0] c, input logic e, input logic [4:0] tag,
                           input logic [15:0] s, input logic [15:0] f);
    stim_row_t r;
    r            = '0;
    r.ch         = c;
    r.eoi        = e;
    r.typed      = 1'b1;
    r.want.tag   = tag;
    r.want.first = s;
    r.want.after = f;
    r.want.last  = 1'b1;
    stim_rows.push_back(r);
  endtask

  task automatic put_byte(input logic [7:0] c);
    src_beats.push_back({1'b0, c});
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    return IDENT_CHARS[$urandom_range(0, IDENT_CHARS.len() - 1)];
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    do b = 8'($urandom); while (b == "\n");
    return b;
  endfunction

  task automatic add_lexeme();
    string w;
    int n;
    logic [7:0] b;
    case ($urandom_range(0, LX_JUNK))
      LX_KEYWORD: begin
        w = kw_word[$urandom_range(0, 5)];
        n = $urandom_range(0, 3);
        if (n == 0) w = w.substr(0, w.len() - 2);
        put_text(w);
        if (n == 1) put_byte(word_char());
      end
      LX_IDENT: begin
        do b = word_char(); while (numeral_char(b));
        put_byte(b);
        repeat ($urandom_range(0, 7)) put_byte(word_char());
      end
      LX_NUMBER: begin
        put_byte(8'("0" + $urandom_range(0, 9)));
        repeat ($urandom_range(0, 5))
          put_byte(($urandom_range(0, 3) == 0) ? "_" : 8'("0" + $urandom_range(0, 9)));
      end
      LX_PUNCT: put_byte(PUNCT_CHARS[$urandom_range(0, PUNCT_CHARS.len() - 1)]);
      LX_SPACE: begin
        repeat ($urandom_range(1, 3))
          put_byte(BLANK_CHARS[$urandom_range(0, BLANK_CHARS.len() - 1)]);
      end
      LX_COMMENT: begin
        put_text("//");
        repeat ($urandom_range(0, 6)) put_byte(any_but_newline());
        if ($urandom_range(0, 7) != 0) put_byte("\n");
      end
      LX_SLASH: put_byte("/");
      default: begin
        do b = 8'($urandom); while (starts_token(b));
        put_byte(b);
        repeat ($urandom_range(0, 4)) put_byte(any_but_newline());
      end
    endcase
  endtask

  initial begin
    int rand_beats;
    string tail;
    rand_beats = 0;
    clear_lexer();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    row(8'h00, 1'b0);
    row(8'hFF, 1'b0);
    row_typed("\n", 1'b0, TAG_INVALID, 16'd0, 16'd2);
    row("/", 1'b0);
    row("+", 1'b0);
    row("/", 1'b0);
    row("/", 1'b0);
    row(")", 1'b0);
    row("\n", 1'b0);
    row("f", 1'b0);
    row("u", 1'b0);
    row("n", 1'b0);
    row("(", 1'b0);
    row("_", 1'b0);
    row("9", 1'b0);
    row(" ", 1'b0);
    row("1", 1'b0);
    row("_", 1'b0);
    row("0", 1'b0);
    row("x", 1'b0);
    row("Z", 1'b0);
    row(8'h00, 1'b1);
    row_typed(8'hFF, 1'b1, TAG_EOF, 16'd0, 16'd0);
    row("/", 1'b0);
    row(8'h00, 1'b1);
    row("/", 1'b0);
    row("/", 1'b0);
    row("a", 1'b0);
    row_typed(8'h00, 1'b1, TAG_EOF, 16'd3, 16'd3);
    foreach (stim_rows[i])
      send_beat(stim_rows[i].ch, stim_rows[i].eoi, stim_rows[i].typed, stim_rows[i].want);

    tail = "ab 12(x)//c\n/+";
    for (int i = 0; i < tail.len(); i++) send_beat(tail[i], 1'b0, 1'b0, '0);
    send_beat(8'h00, 1'b0, 1'b0, '0);
    send_beat("q", 1'b0, 1'b0, '0);
    send_beat(";", 1'b0, 1'b0, '0);
    send_beat(8'h00, 1'b1, 1'b0, '0);
    sources = 3;

    while (rand_beats < 1000) begin
      src_beats.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(4, 20))
          src_beats.push_back({($urandom_range(0, 15) == 0), 8'($urandom)});
      end else begin
        repeat ($urandom_range(1, 10)) begin
          add_lexeme();
          if ($urandom_range(0, 1) == 0) put_byte(BLANK_CHARS[$urandom_range(0, 3)]);
        end
      end
      if ($urandom_range(0, 7) != 0) src_beats.push_back({1'b1, 8'($urandom)});
      steady_send = ($urandom_range(0, 5) == 0);
      foreach (src_beats[i]) begin
        send_beat(src_beats[i][7:0], src_beats[i][8], 1'b0, '0);
        rand_beats++;
      end
      sources++;
    end
    push_i <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Lexed %0d source beats in about %0d sources of words, numbers and junk.",
             beats_sent, sources);
    $display("Compared %0d tokens: %0d keywords, %0d beats that gave two tokens.",
             tokens_checked, keyword_tokens, double_beats);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
